/* sv/ssw_pkg.sv */
// Shared types, constants and a helper function for the signature scan word capture block.
`default_nettype none

package ssw_pkg;

   localparam int WinLen   = 78;
   localparam int SigLen   = 17;
   localparam int CountW   = $clog2(WinLen + 1);
   localparam int NumWords = 8;
   localparam int SlotLen  = 7;

   localparam logic [7:0] SigBytes [SigLen] = '{
      8'h56, 8'h57, 8'h50, 8'h8D, 8'h45, 8'hF4, 8'h64, 8'hA3,
      8'h00, 8'h00, 8'h00, 8'h00, 8'h8B, 8'h73, 8'h08, 8'h8B, 8'hCE
   };

   localparam int SlotOffsets [NumWords] = '{0, 7, 14, 23, 30, 37, 47, 54};

   localparam int AnchorAPos = SigLen + 21;
   localparam int AnchorBPos = SigLen + 44;

   localparam logic [7:0] AnchorMov   = 8'h8B;
   localparam logic [7:0] AnchorAByte = 8'h06;
   localparam logic [7:0] AnchorBByte = 8'h40;
   localparam logic [7:0] AnchorBDisp = 8'h2C;
   localparam logic [7:0] SlotOpcode  = 8'hC7;
   localparam logic [7:0] SlotModrm   = 8'h45;

   typedef logic [WinLen-1:0][7:0] window_type;
   typedef logic [NumWords-1:0][31:0] word_set_type;

   typedef struct packed {
      logic         hit;
      word_set_type words;
   } match_type;

   // A slot yields its immediate word only when it opens with the expected opcode pair.
   function automatic logic [31:0] slot_word(input window_type win, input int pos);
      logic [31:0] word;
      word = {win[pos + 3], win[pos + 4], win[pos + 5], win[pos + 6]};
      if (win[pos] != SlotOpcode || win[pos + 1] != SlotModrm) begin
         word = '0;
      end
      return word;
   endfunction

endpackage

`default_nettype wire

/* sv/signature_scan_word_capture.sv */
// Top level of the signature scan word capture block.
`default_nettype none

// The block accepts one buffer byte per cycle and keeps the 78 bytes before it in a shift
// window. When a byte is accepted, the window as it stood before that byte is checked for
// the signature and anchors; the first hit, or the final byte of a buffer without a hit,
// loads the result register, and its beat is offered on the next cycle. The only limit on
// rate is the single result register, so req_ready drops only while a result beat waits and
// rsp_ready is low. After the first hit no further results are produced until reset.
module signature_scan_word_capture
   import ssw_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_data_byte,
   input  logic        req_end_of_buffer,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_found,
   output logic [31:0] rsp_key_word_a,
   output logic [31:0] rsp_key_word_b,
   output logic [31:0] rsp_key_word_c,
   output logic [31:0] rsp_key_word_d,
   output logic [31:0] rsp_vector_word_a,
   output logic [31:0] rsp_vector_word_b,
   output logic [31:0] rsp_vector_word_c,
   output logic [31:0] rsp_vector_word_d
);

   window_type        window_ff, window_in;
   logic [CountW-1:0] bytes_seen_ff, bytes_seen_in;
   logic              search_done_ff, search_done_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_found_ff, rsp_found_in;
   word_set_type      rsp_words_ff, rsp_words_in;

   match_type match;
   logic      accept;
   logic      emit;

   ssw_matcher u_matcher (
      .window     (window_ff),
      .bytes_seen (bytes_seen_ff),
      .match      (match)
   );

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;
   assign emit      = accept && !search_done_ff && (match.hit || req_end_of_buffer);

   always_comb begin
      window_in      = window_ff;
      bytes_seen_in  = bytes_seen_ff;
      search_done_in = search_done_ff;
      rsp_found_in   = rsp_found_ff;
      rsp_words_in   = rsp_words_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;

      if (accept) begin
         window_in = {req_data_byte, window_ff[WinLen-1:1]};
         if (bytes_seen_ff != CountW'(WinLen)) begin
            bytes_seen_in = bytes_seen_ff + CountW'(1);
         end
         if (req_end_of_buffer) begin
            window_in     = '0;
            bytes_seen_in = '0;
         end
      end

      if (emit) begin
         rsp_valid_in = 1'b1;
         rsp_found_in = match.hit;
         rsp_words_in = match.hit ? match.words : '0;
         if (match.hit) begin
            search_done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff      <= '0;
         bytes_seen_ff  <= '0;
         search_done_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         window_ff      <= window_in;
         bytes_seen_ff  <= bytes_seen_in;
         search_done_ff <= search_done_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_found_ff <= rsp_found_in;
      rsp_words_ff <= rsp_words_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_found         = rsp_found_ff;
   assign rsp_key_word_a    = rsp_words_ff[0];
   assign rsp_key_word_b    = rsp_words_ff[1];
   assign rsp_key_word_c    = rsp_words_ff[2];
   assign rsp_key_word_d    = rsp_words_ff[3];
   assign rsp_vector_word_a = rsp_words_ff[4];
   assign rsp_vector_word_b = rsp_words_ff[5];
   assign rsp_vector_word_c = rsp_words_ff[6];
   assign rsp_vector_word_d = rsp_words_ff[7];

   // A found beat always comes with the sticky flag already set.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_found_ff |-> search_done_ff)
      else $error("found beat without search_done set");

   // The sticky flag only rises together with a found beat loaded into the result register.
   assert property (@(posedge clock) disable iff (reset)
      $rose(search_done_ff) |-> rsp_valid_ff && rsp_found_ff)
      else $error("search_done rose without a found beat");

   // A beat for a buffer end without a hit carries all-zero words.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_found_ff |-> rsp_words_ff == '0)
      else $error("not-found beat carries nonzero words");

   // The byte count saturates at the window length.
   assert property (@(posedge clock) disable iff (reset)
      bytes_seen_ff <= CountW'(WinLen))
      else $error("bytes_seen exceeds window length");

endmodule

`default_nettype wire

/* sv/ssw_matcher.sv */
// Signature and anchor compare over the byte window, with extraction of the eight words.
`default_nettype none

module ssw_matcher
   import ssw_pkg::*;
(
   input  window_type        window,
   input  logic [CountW-1:0] bytes_seen,
   output match_type         match
);

   logic sig_ok;
   logic anchor_ok;

   always_comb begin
      sig_ok = 1'b1;
      for (int i = 0; i < SigLen; i++) begin
         if (window[i] != SigBytes[i]) begin
            sig_ok = 1'b0;
         end
      end
   end

   assign anchor_ok = (window[AnchorAPos] == AnchorMov) &&
                      (window[AnchorAPos + 1] == AnchorAByte) &&
                      (window[AnchorBPos] == AnchorMov) &&
                      (window[AnchorBPos + 1] == AnchorBByte) &&
                      (window[AnchorBPos + 2] == AnchorBDisp);

   always_comb begin
      match.hit = (bytes_seen == CountW'(WinLen)) && sig_ok && anchor_ok;
      for (int w = 0; w < NumWords; w++) begin
         match.words[w] = slot_word(window, SigLen + SlotOffsets[w]);
      end
   end

endmodule

`default_nettype wire
